// ===== hdl/gsg_pkg.sv =====
// Constants and helper function shared by the Gaussian sample generator.
package gsg_pkg;

  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int SAMPLE_WIDTH = SAMPLE_FRAC_BITS + 5;
  localparam int QUANT_SHIFT = 58 - SAMPLE_FRAC_BITS;
  localparam logic [63:0] QUANT_HALF = 64'd1 << (QUANT_SHIFT - 1);
  localparam logic [63:0] SAMPLE_LIM = 64'd1 << (SAMPLE_WIDTH - 1);

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] FIN_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] FIN_MUL_B = 64'h94d049bb133111eb;
  localparam logic [31:0] TWO_LN2_Q30 = 32'h58B90BFC;
  localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam logic [4:0] SQ_LAST = 5'd31;
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST = 5'd29;
  localparam logic [5:0] NORM_MAX = 6'd52;

  localparam int HORNER_STEPS = 9;
  localparam logic [3:0] HS_SIN_LAST = 4'd3;
  localparam logic [3:0] HS_COS_FIRST = 4'd4;
  localparam logic [3:0] HS_COS_LAST = 4'd8;
  localparam logic [6:0] HORNER_DIV [0:HORNER_STEPS-1] = '{
    7'd72, 7'd42, 7'd20, 7'd6, 7'd90, 7'd56, 7'd30, 7'd12, 7'd2
  };

  function automatic logic [SAMPLE_WIDTH-1:0] quantize(input logic [63:0] prod,
                                                       input logic neg);
    logic [63:0] mag;
    logic [63:0] res;
    mag = (prod + QUANT_HALF) >> QUANT_SHIFT;
    if (!neg) begin
      res = (mag > SAMPLE_LIM - 64'd1) ? SAMPLE_LIM - 64'd1 : mag;
    end else begin
      if (mag > SAMPLE_LIM) begin
        mag = SAMPLE_LIM;
      end
      res = 64'd0 - mag;
    end
    return res[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

// ===== hdl/gaussian_sample_generator.sv =====
// Gaussian sample generator: splitmix64 words, Box-Muller in fixed point, spare sine sample.
//
// Each transfer on the input yields one transfer on the output. When a sine spare is held
// and no key is loaded, the spare passes through the done state to the output register. A
// fresh pair is built from two splitmix64 words through one shared 32x32 multiplier, a
// one-bit-per-cycle normalisation of the uniform, 32 squaring steps for the logarithm, a
// bit-serial square root of 32 steps, and nine Horner steps for sine and cosine, each
// closed by a bit-serial division of 30 steps. A new input is taken whenever the
// sequencer is idle, even while the last result still waits in the output register.
module gaussian_sample_generator (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     load_key,
  input  logic [63:0]                              new_key,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [gsg_pkg::SAMPLE_WIDTH-1:0]  sample,
  output logic                                     from_spare
);
  import gsg_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_WORD  = 14'b00000000000010,
    S_MUL   = 14'b00000000000100,
    S_NORM  = 14'b00000000001000,
    S_SQ    = 14'b00000000010000,
    S_LN    = 14'b00000000100000,
    S_SQRT  = 14'b00000001000000,
    S_ANG   = 14'b00000010000000,
    S_X2    = 14'b00000100000000,
    S_HMUL  = 14'b00001000000000,
    S_HDIV  = 14'b00010000000000,
    S_SIN   = 14'b00100000000000,
    S_QUANT = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [63:0] pos;
  logic [SAMPLE_WIDTH-1:0] spare;
  logic spare_valid;
  logic [63:0] z;
  logic [63:0] acc;
  logic [63:0] p;
  logic [1:0] mph;
  logic mul_sel;
  logic word_idx;
  logic ph;
  logic [52:0] nrm;
  logic [5:0] shc;
  logic [31:0] lx;
  logic [31:0] f;
  logic [4:0] cnt;
  logic [63:0] sqn;
  logic [33:0] rem;
  logic [31:0] root;
  logic [31:0] rad;
  logic [31:0] turn;
  logic [2:0] k;
  logic [29:0] xang;
  logic [29:0] x2;
  logic [30:0] ht;
  logic [3:0] hs;
  logic [29:0] dv;
  logic [6:0] drem;
  logic [30:0] sin_v;
  logic [30:0] cos_v;
  logic qsel;
  logic [SAMPLE_WIDTH-1:0] res;
  logic res_fs;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] fin_const;
  logic [63:0] prod;
  logic [63:0] word;
  logic [63:0] pz;
  logic [52:0] m1;
  logic [37:0] tq;
  logic [29:0] rr;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic sq_ge;
  logic [35:0] rem_new;
  logic [7:0] drem_sh;
  logic div_ge;
  logic [7:0] drem_new;
  logic [29:0] quo;
  logic [30:0] ht_new;
  logic [30:0] ta;
  logic [30:0] tb;
  logic [30:0] cm;
  logic [30:0] sm;
  logic cneg;
  logic sneg;
  logic [30:0] trig;
  logic tneg;
  logic [SAMPLE_WIDTH-1:0] qval;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign fin_const = mul_sel ? FIN_MUL_B : FIN_MUL_A;
  assign prod = acc + {p[31:0], 32'd0};
  assign word = prod ^ (prod >> 31);
  assign pz = pos + GOLDEN_STEP;
  assign m1 = (word[63:11] == 53'd0) ? 53'd1 : word[63:11];
  assign tq = {shc + 6'd1, 32'd0} - {6'd0, f};
  assign rr = turn[29] ? (30'h2000_0000 - {1'b0, turn[28:0]}) : {1'b0, turn[28:0]};

  assign rem_sh = {rem, sqn[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign sq_ge = (rem_sh >= trial);
  assign rem_new = sq_ge ? rem_sh - trial : rem_sh;

  assign drem_sh = {drem, dv[29]};
  assign div_ge = (drem_sh >= {1'b0, HORNER_DIV[hs]});
  assign drem_new = div_ge ? drem_sh - {1'b0, HORNER_DIV[hs]} : drem_sh;
  assign quo = {dv[28:0], div_ge};
  assign ht_new = Q30_ONE - {1'b0, quo};

  always_comb begin
    if (k[0]) begin
      ta = sin_v;
      tb = cos_v;
    end else begin
      ta = cos_v;
      tb = sin_v;
    end
    case (k[2:1])
      2'd0: begin
        cm = ta;
        sm = tb;
        cneg = 1'b0;
        sneg = 1'b0;
      end
      2'd1: begin
        cm = tb;
        sm = ta;
        cneg = 1'b1;
        sneg = 1'b0;
      end
      2'd2: begin
        cm = ta;
        sm = tb;
        cneg = 1'b1;
        sneg = 1'b1;
      end
      default: begin
        cm = tb;
        sm = ta;
        cneg = 1'b0;
        sneg = 1'b1;
      end
    endcase
    trig = qsel ? sm : cm;
    tneg = qsel ? sneg : cneg;
  end

  assign qval = quantize(p, tneg);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_MUL: begin
        case (mph)
          2'd0: begin
            mul_a = z[31:0];
            mul_b = fin_const[31:0];
          end
          2'd1: begin
            mul_a = z[31:0];
            mul_b = fin_const[63:32];
          end
          default: begin
            mul_a = z[63:32];
            mul_b = fin_const[31:0];
          end
        endcase
      end
      S_SQ: begin
        mul_a = lx;
        mul_b = lx;
      end
      S_LN: begin
        mul_a = {2'b00, tq[37:8]};
        mul_b = TWO_LN2_Q30;
      end
      S_ANG: begin
        mul_a = {2'b00, rr};
        mul_b = PI_Q30;
      end
      S_X2: begin
        mul_a = {2'b00, xang};
        mul_b = {2'b00, xang};
      end
      S_HMUL: begin
        mul_a = {2'b00, x2};
        mul_b = {1'b0, ht};
      end
      S_SIN: begin
        mul_a = {2'b00, xang};
        mul_b = {1'b0, ht};
      end
      S_QUANT: begin
        mul_a = rad;
        mul_b = {1'b0, trig};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= 64'd0;
      spare_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (load_key) begin
              pos <= new_key;
            end
            if (spare_valid && !load_key) begin
              res <= spare;
              res_fs <= 1'b1;
              spare_valid <= 1'b0;
              state <= S_DONE;
            end else begin
              spare_valid <= 1'b0;
              word_idx <= 1'b0;
              state <= S_WORD;
            end
          end
        end
        S_WORD: begin
          pos <= pz;
          z <= pz ^ (pz >> 30);
          mul_sel <= 1'b0;
          mph <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          case (mph)
            2'd0: begin
              mph <= 2'd1;
            end
            2'd1: begin
              acc <= p;
              mph <= 2'd2;
            end
            2'd2: begin
              acc <= prod;
              mph <= 2'd3;
            end
            default: begin
              mph <= 2'd0;
              if (!mul_sel) begin
                z <= prod ^ (prod >> 27);
                mul_sel <= 1'b1;
              end else if (!word_idx) begin
                nrm <= m1;
                word_idx <= 1'b1;
                state <= S_WORD;
              end else begin
                turn <= word[63:32];
                shc <= 6'd0;
                state <= S_NORM;
              end
            end
          endcase
        end
        S_NORM: begin
          if (nrm[52]) begin
            lx <= nrm[52:21];
            cnt <= 5'd0;
            ph <= 1'b0;
            state <= S_SQ;
          end else begin
            nrm <= {nrm[51:0], 1'b0};
            shc <= shc + 6'd1;
          end
        end
        S_SQ: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            f <= {f[30:0], p[63]};
            lx <= p[63] ? p[63:32] : p[62:31];
            cnt <= cnt + 5'd1;
            if (cnt == SQ_LAST) begin
              state <= S_LN;
            end
          end
        end
        S_LN: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            sqn <= {1'b0, p[60:22], 24'd0};
            rem <= 34'd0;
            root <= 32'd0;
            cnt <= 5'd0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem <= rem_new[33:0];
          root <= {root[30:0], sq_ge};
          sqn <= {sqn[61:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == SQRT_LAST) begin
            rad <= {root[30:0], sq_ge};
            k <= turn[31:29];
            state <= S_ANG;
          end
        end
        S_ANG: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            xang <= p[60:31];
            state <= S_X2;
          end
        end
        S_X2: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            x2 <= p[59:30];
            ht <= Q30_ONE;
            hs <= 4'd0;
            state <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            dv <= p[59:30];
            drem <= 7'd0;
            cnt <= 5'd0;
            state <= S_HDIV;
          end
        end
        S_HDIV: begin
          drem <= drem_new[6:0];
          dv <= quo;
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) begin
            ht <= ht_new;
            if (hs == HS_SIN_LAST) begin
              state <= S_SIN;
            end else if (hs == HS_COS_LAST) begin
              cos_v <= ht_new;
              qsel <= 1'b0;
              state <= S_QUANT;
            end else begin
              hs <= hs + 4'd1;
              state <= S_HMUL;
            end
          end
        end
        S_SIN: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            sin_v <= p[60:30];
            ht <= Q30_ONE;
            hs <= HS_COS_FIRST;
            state <= S_HMUL;
          end
        end
        S_QUANT: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (!qsel) begin
              res <= qval;
              res_fs <= 1'b0;
              qsel <= 1'b1;
            end else begin
              spare <= qval;
              spare_valid <= 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            sample <= $signed(res);
            from_spare <= res_fs;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fresh_leaves_spare: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && !res_fs) |-> spare_valid)
    else $error("Fresh result delivered without a stored spare.");

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (rem <= {1'b0, root, 1'b0}))
    else $error("Square root remainder out of range.");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_HDIV) |-> (drem < HORNER_DIV[hs]))
    else $error("Division remainder not below the divisor.");

  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM) |-> (shc <= NORM_MAX))
    else $error("Normalisation shift ran past the uniform width.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("Input transfer did not start any work.");

endmodule
